// ===== rtl/hsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types, constants and helper functions for the humidity sensor
// frame decoder.
// ----------------------------------------------------------------------------
package hsfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam int RAW_W  = 16;
  localparam int PROD_W = 34;
  localparam int QUO_W  = 18;

  localparam logic [17:0] TEMP_GAIN   = 18'd175000;
  localparam logic [16:0] HUM_GAIN    = 17'd125000;
  localparam logic [18:0] TEMP_OFFSET = 19'd45000;
  localparam logic [17:0] HUM_OFFSET  = 18'd6000;
  localparam logic [17:0] HUM_MAX     = 18'd100000;
  localparam logic [18:0] FULL_SCALE  = 19'd65535;

  // position of the next byte within the six-byte response
  typedef enum logic [2:0] {
    POS_B0,
    POS_B1,
    POS_CRC1,
    POS_B3,
    POS_B4,
    POS_CRC2
  } pos_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] serial;
    logic        word1_ok;
    logic        word2_ok;
  } frame_t;

  // one byte through crc-8, msb first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(p / 65535): p = 65536*a + b gives a + floor((a + b) / 65535),
  // and a + b stays below four times the divisor
  function automatic logic [QUO_W-1:0] div_full_scale(input logic [PROD_W-1:0] p);
    logic [17:0] a;
    logic [18:0] s;
    logic [1:0]  c;
    a = p[PROD_W-1:16];
    s = {1'b0, a} + {3'b000, p[15:0]};
    c = 2'd0;
    if (s >= 3 * FULL_SCALE) begin
      c = 2'd3;
    end else if (s >= 2 * FULL_SCALE) begin
      c = 2'd2;
    end else if (s >= FULL_SCALE) begin
      c = 2'd1;
    end
    return a + {16'd0, c};
  endfunction

endpackage

// ===== rtl/hsfd_scale.sv =====
// ----------------------------------------------------------------------------
// hsfd_scale
// Two-stage result path: raw readings times gain, then divide by full
// scale, offset and clamp into the output register.
// ----------------------------------------------------------------------------
module hsfd_scale
  import hsfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               frame_valid_i,
  input  frame_t             frame_i,
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               frame_kind_o,
  output logic [31:0]        serial_number_o,
  output logic signed [17:0] temp_mdegc_o,
  output logic [16:0]        rh_mpct_o,
  output logic               first_word_ok_o,
  output logic               second_word_ok_o
);

  logic              s1_valid_q, s1_valid_d;
  frame_t            s1_frame_q;
  logic [PROD_W-1:0] t_prod_q, h_prod_q;
  logic              out_valid_q, out_valid_d;
  logic              out_adv;

  logic [QUO_W-1:0]  t_quo, h_quo, h_off;
  logic signed [18:0] t_wide;
  logic [16:0]       hum_d;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign busy_o     = s1_valid_q && !out_adv;
  assign s1_valid_d = frame_valid_i || (s1_valid_q && !out_adv);
  assign out_valid_d = out_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_valid_i) begin
      s1_frame_q <= frame_i;
      t_prod_q   <= PROD_W'(TEMP_GAIN) * PROD_W'(frame_i.serial[31:16]);
      h_prod_q   <= PROD_W'(HUM_GAIN) * PROD_W'(frame_i.serial[RAW_W-1:0]);
    end
  end

  always_comb begin
    t_quo  = div_full_scale(t_prod_q);
    h_quo  = div_full_scale(h_prod_q);
    t_wide = signed'({1'b0, t_quo}) - signed'(TEMP_OFFSET);
    h_off  = h_quo - HUM_OFFSET;
    if (h_quo < HUM_OFFSET) begin
      hum_d = 17'd0;
    end else if (h_off > HUM_MAX) begin
      hum_d = HUM_MAX[16:0];
    end else begin
      hum_d = h_off[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      frame_kind_o     <= s1_frame_q.kind;
      serial_number_o  <= s1_frame_q.serial;
      temp_mdegc_o     <= t_wide[17:0];
      rh_mpct_o        <= hum_d;
      first_word_ok_o  <= s1_frame_q.word1_ok;
      second_word_ok_o <= s1_frame_q.word2_ok;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/humidity_sensor_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder
// Six-byte response parser with crc-8 checks and temperature / humidity
// scaling.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the input is not stalled; at most one result per six bytes.
// Result path: after the sixth byte is taken, the result passes through the
//   product register and then the output register.
// The input stalls only while a finished result waits and the product stage
//   is full behind it.
// Reset: position, crc, flags, kind and valids clear at once; held bytes do not.
module humidity_sensor_frame_decoder
  import hsfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               first_i,
  input  logic               mode_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               frame_kind_o,
  output logic [31:0]        serial_number_o,
  output logic signed [17:0] temp_mdegc_o,
  output logic [16:0]        rh_mpct_o,
  output logic               first_word_ok_o,
  output logic               second_word_ok_o
);

  pos_e       pos_q, pos_d, pos_cur;
  logic [7:0] crc_q, crc_d;
  logic       ok1_q, ok1_d;
  logic       kind_q, kind_d;
  logic [7:0] held_q [4];
  logic       accept;
  logic       busy;
  logic       frame_valid;
  frame_t     frame;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  always_comb begin
    pos_cur     = first_i ? POS_B0 : pos_q;
    kind_d      = first_i ? mode_i : kind_q;
    pos_d       = pos_q;
    crc_d       = crc_q;
    ok1_d       = ok1_q;
    frame_valid = 1'b0;
    case (pos_cur)
      POS_B0: begin
        crc_d = crc8_feed(CRC_INIT, rx_byte_i);
        pos_d = POS_B1;
      end
      POS_B1: begin
        crc_d = crc8_feed(crc_q, rx_byte_i);
        pos_d = POS_CRC1;
      end
      POS_CRC1: begin
        ok1_d = (crc_q == rx_byte_i);
        crc_d = CRC_INIT;
        pos_d = POS_B3;
      end
      POS_B3: begin
        crc_d = crc8_feed(CRC_INIT, rx_byte_i);
        pos_d = POS_B4;
      end
      POS_B4: begin
        crc_d = crc8_feed(crc_q, rx_byte_i);
        pos_d = POS_CRC2;
      end
      POS_CRC2: begin
        crc_d       = CRC_INIT;
        pos_d       = POS_B0;
        frame_valid = accept;
      end
      default: begin
        pos_d = POS_B0;
      end
    endcase
    frame.kind     = kind_q;
    frame.serial   = {held_q[0], held_q[1], held_q[2], held_q[3]};
    frame.word1_ok = ok1_q;
    frame.word2_ok = (crc_q == rx_byte_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_B0;
      crc_q  <= CRC_INIT;
      ok1_q  <= 1'b0;
      kind_q <= 1'b0;
    end else if (accept) begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      ok1_q  <= ok1_d;
      kind_q <= kind_d;
    end
  end

  // data bytes 0,1,3,4 land in slots 0..3
  always_ff @(posedge clk_i) begin
    if (accept) begin
      case (pos_cur)
        POS_B0:  held_q[0] <= rx_byte_i;
        POS_B1:  held_q[1] <= rx_byte_i;
        POS_B3:  held_q[2] <= rx_byte_i;
        POS_B4:  held_q[3] <= rx_byte_i;
        default: ;
      endcase
    end
  end

  hsfd_scale u_scale (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .frame_valid_i    (frame_valid),
    .frame_i          (frame),
    .busy_o           (busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_kind_o     (frame_kind_o),
    .serial_number_o  (serial_number_o),
    .temp_mdegc_o     (temp_mdegc_o),
    .rh_mpct_o        (rh_mpct_o),
    .first_word_ok_o  (first_word_ok_o),
    .second_word_ok_o (second_word_ok_o)
  );

endmodule

// ===== rtl/hsfd_checker.sv =====
// ----------------------------------------------------------------------------
// hsfd_checker
// Port-level checks for the humidity sensor frame decoder, bound to the top.
// ----------------------------------------------------------------------------
module hsfd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [31:0]        serial_number_o,
  input logic signed [17:0] temp_mdegc_o,
  input logic [16:0]        rh_mpct_o
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(serial_number_o)
      && $stable(temp_mdegc_o) && $stable(rh_mpct_o))
    else $error("result changed while stalled");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rh_mpct_o <= 17'd100000)
    else $error("humidity out of range");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> temp_mdegc_o >= -18'sd45000 && temp_mdegc_o <= 18'sd130000)
    else $error("temperature out of range");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .serial_number_o (serial_number_o),
  .temp_mdegc_o    (temp_mdegc_o),
  .rh_mpct_o       (rh_mpct_o)
);
